// ===== rtl/hcir_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hcir_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CMDQ_DEPTH = 2;

  localparam logic [7:0] H4_TYPE_COMMAND   = 8'h01;
  localparam logic [7:0] H4_TYPE_EVENT     = 8'h04;
  localparam logic [7:0] EVT_CMD_COMPLETE  = 8'h0E;
  localparam logic [7:0] NUM_CMD_PACKETS   = 8'h01;
  localparam logic [7:0] STATUS_SUCCESS    = 8'h00;
  localparam logic [7:0] STATUS_DISALLOWED = 8'h0C;

  localparam logic [15:0] OP_RESET            = 16'h0C03;
  localparam logic [15:0] OP_READ_BD_ADDR     = 16'h1009;
  localparam logic [15:0] OP_WRITE_BD_ADDR    = 16'hFC01;
  localparam logic [15:0] OP_DOWNLOAD_MINIDRV = 16'hFC2E;
  localparam logic [15:0] OP_INQUIRY_CANCEL   = 16'h0402;
  localparam logic [15:0] OP_READ_BUFFER_SIZE = 16'h1005;
  localparam logic [15:0] OP_READ_PAGE_TO     = 16'h0C17;
  localparam logic [15:0] OP_READ_LOCAL_FEAT  = 16'h1003;

  localparam logic [15:0] RST_PAGE_TIMEOUT = 16'h2000;
  localparam logic [15:0] RST_ACL_LEN      = 16'd192;
  localparam logic [7:0]  RST_SCO_LEN      = 8'd72;
  localparam logic [15:0] RST_ACL_CNT      = 16'd1;
  localparam logic [15:0] RST_SCO_CNT      = 16'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAGE_TIMEOUT = 3'd0,
    CFG_ACL_LEN      = 3'd1,
    CFG_SCO_LEN      = 3'd2,
    CFG_ACL_CNT      = 3'd3,
    CFG_SCO_CNT      = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    CLS_OTHER,
    CLS_READ_BD_ADDR,
    CLS_INQUIRY_CANCEL,
    CLS_READ_BUFFER_SIZE,
    CLS_READ_PAGE_TO,
    CLS_READ_LOCAL_FEAT,
    CLS_DOWNLOAD_MINIDRV
  } cls_t;

  typedef struct packed {
    logic [15:0] opcode;
    cls_t        cls;
    logic        set_addr;
    logic [47:0] addr;
  } cmd_t;

  function automatic cls_t classify(input logic [15:0] op);
    cls_t c;
    unique case (op)
      OP_READ_BD_ADDR:     c = CLS_READ_BD_ADDR;
      OP_INQUIRY_CANCEL:   c = CLS_INQUIRY_CANCEL;
      OP_READ_BUFFER_SIZE: c = CLS_READ_BUFFER_SIZE;
      OP_READ_PAGE_TO:     c = CLS_READ_PAGE_TO;
      OP_READ_LOCAL_FEAT:  c = CLS_READ_LOCAL_FEAT;
      OP_DOWNLOAD_MINIDRV: c = CLS_DOWNLOAD_MINIDRV;
      default:             c = CLS_OTHER;
    endcase
    return c;
  endfunction

  // number of return parameters after the status byte
  function automatic logic [3:0] ret_param_count(input cls_t c);
    logic [3:0] n;
    unique case (c)
      CLS_READ_BD_ADDR:     n = 4'd6;
      CLS_READ_BUFFER_SIZE: n = 4'd7;
      CLS_READ_PAGE_TO:     n = 4'd2;
      CLS_READ_LOCAL_FEAT:  n = 4'd8;
      default:              n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] local_feature(input logic [2:0] i);
    logic [7:0] f;
    unique case (i)
      3'd0: f = 8'hA4;
      3'd1: f = 8'h08;
      3'd2: f = 8'h00;
      3'd3: f = 8'hC0;
      3'd4: f = 8'h18;
      3'd5: f = 8'h1E;
      3'd6: f = 8'h79;
      3'd7: f = 8'h83;
      default: f = 8'h00;
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/hcir_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hcir_parser (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_xfer,
  input  wire logic [7:0]           host_byte,
  output hcir_pkg::cmd_t            cmd,
  output logic                      cmd_push
);
  import hcir_pkg::*;

  logic [8:0]  byte_count;
  logic [15:0] command_opcode;
  logic [7:0]  parameter_length;
  logic [7:0]  first_parameters [6];

  logic [8:0]  pos_inc;
  logic [8:0]  pos_rel;
  logic [7:0]  len_eff;
  logic        in_cmd;
  logic        done;
  logic        keep_param;
  logic [47:0] addr_cur;

  assign in_cmd     = (byte_count != 9'd0);
  assign pos_inc    = byte_count + 9'd1;
  assign pos_rel    = byte_count - 9'd4;
  assign len_eff    = (byte_count == 9'd3) ? host_byte : parameter_length;
  assign keep_param = (byte_count >= 9'd4) && (byte_count <= 9'd9);
  assign done       = in_cmd && (pos_inc >= 9'd4)
                      && ({1'b0, pos_inc} >= (10'd4 + {2'b00, len_eff}));

  // the closing byte may itself be the sixth parameter
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      if (keep_param && (pos_rel[2:0] == 3'(i))) begin
        addr_cur[8*i +: 8] = host_byte;
      end else begin
        addr_cur[8*i +: 8] = first_parameters[i];
      end
    end
  end

  assign cmd_push     = in_xfer && done;
  assign cmd.opcode   = command_opcode;
  assign cmd.cls      = classify(command_opcode);
  assign cmd.set_addr = (command_opcode == OP_WRITE_BD_ADDR) && (len_eff >= 8'd6);
  assign cmd.addr     = addr_cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count       <= '0;
      command_opcode   <= '0;
      parameter_length <= '0;
    end else if (in_xfer) begin
      if (!in_cmd) begin
        if (host_byte == H4_TYPE_COMMAND) begin
          byte_count <= 9'd1;
        end
      end else begin
        priority if (byte_count == 9'd1) begin
          command_opcode <= {8'h00, host_byte};
        end else if (byte_count == 9'd2) begin
          command_opcode <= {host_byte, command_opcode[7:0]};
        end else if (byte_count == 9'd3) begin
          parameter_length <= host_byte;
        end else begin
        end
        byte_count <= done ? 9'd0 : pos_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && keep_param) begin
      first_parameters[pos_rel[2:0]] <= host_byte;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hcir_cmdq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hcir_cmdq (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr_en,
  input  wire hcir_pkg::cmd_t wr_data,
  output logic                q_full,
  input  wire logic           rd_en,
  output hcir_pkg::cmd_t      rd_data,
  output logic                q_empty
);
  import hcir_pkg::*;

  localparam int unsigned PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(CMDQ_DEPTH + 1);

  cmd_t             slots [CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign q_full  = (count == CNT_W'(CMDQ_DEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hcir_responder.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hcir_responder (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire hcir_pkg::cmd_t                  cmd,
  input  wire logic                            cmd_empty,
  output logic                                 cmd_pop,
  input  wire logic                            cfg_wr,
  input  wire logic [hcir_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [hcir_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                                 out_valid,
  input  wire logic                            out_take,
  output logic [7:0]                           reply_byte,
  output logic                                 reply_last
);
  import hcir_pkg::*;

  logic [15:0] page_timeout;
  logic [15:0] acl_packet_length;
  logic [7:0]  sco_packet_length;
  logic [15:0] acl_packet_count;
  logic [15:0] sco_packet_count;
  logic [47:0] device_address;

  logic        active;
  logic [3:0]  idx;
  logic [15:0] cur_op;
  cls_t        cur_cls;

  logic [3:0]  nret;
  logic [3:0]  last_idx;
  logic [2:0]  ext;
  logic [7:0]  ret_byte;
  logic [7:0]  gen_byte;
  logic        load;

  assign nret     = ret_param_count(cur_cls);
  assign last_idx = 4'd6 + nret + ((cur_cls == CLS_DOWNLOAD_MINIDRV) ? 4'd2 : 4'd0);
  assign ext      = 3'(idx - 4'd7);
  assign load     = active && (!out_valid || out_take);
  assign cmd_pop  = !active && !cmd_empty;

  always_comb begin
    ret_byte = 8'h00;
    unique case (cur_cls)
      CLS_READ_BD_ADDR: ret_byte = device_address[8*ext +: 8];
      CLS_READ_BUFFER_SIZE: begin
        unique case (ext)
          3'd0: ret_byte = acl_packet_length[7:0];
          3'd1: ret_byte = acl_packet_length[15:8];
          3'd2: ret_byte = sco_packet_length;
          3'd3: ret_byte = acl_packet_count[7:0];
          3'd4: ret_byte = acl_packet_count[15:8];
          3'd5: ret_byte = sco_packet_count[7:0];
          default: ret_byte = sco_packet_count[15:8];
        endcase
      end
      CLS_READ_PAGE_TO: ret_byte = ext[0] ? page_timeout[15:8] : page_timeout[7:0];
      CLS_READ_LOCAL_FEAT: ret_byte = local_feature(ext);
      default: ret_byte = 8'h00;
    endcase
  end

  always_comb begin
    unique case (idx)
      4'd0: gen_byte = H4_TYPE_EVENT;
      4'd1: gen_byte = EVT_CMD_COMPLETE;
      4'd2: gen_byte = 8'(4'd4 + nret);
      4'd3: gen_byte = NUM_CMD_PACKETS;
      4'd4: gen_byte = cur_op[7:0];
      4'd5: gen_byte = cur_op[15:8];
      4'd6: gen_byte = (cur_cls == CLS_INQUIRY_CANCEL) ? STATUS_DISALLOWED : STATUS_SUCCESS;
      default: gen_byte = ret_byte;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      page_timeout      <= RST_PAGE_TIMEOUT;
      acl_packet_length <= RST_ACL_LEN;
      sco_packet_length <= RST_SCO_LEN;
      acl_packet_count  <= RST_ACL_CNT;
      sco_packet_count  <= RST_SCO_CNT;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_PAGE_TIMEOUT: page_timeout      <= cfg_data;
        CFG_ACL_LEN:      acl_packet_length <= cfg_data;
        CFG_SCO_LEN:      sco_packet_length <= cfg_data[7:0];
        CFG_ACL_CNT:      acl_packet_count  <= cfg_data;
        CFG_SCO_CNT:      sco_packet_count  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active         <= 1'b0;
      idx            <= '0;
      out_valid      <= 1'b0;
      device_address <= '0;
    end else begin
      if (cmd_pop) begin
        active <= 1'b1;
        idx    <= '0;
        // the address write never shows in its own reply, so apply it now
        if (cmd.set_addr) begin
          device_address <= cmd.addr;
        end
      end else if (load) begin
        idx <= idx + 4'd1;
        if (idx == last_idx) begin
          active <= 1'b0;
        end
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur_op  <= cmd.opcode;
      cur_cls <= cmd.cls;
    end
    if (load) begin
      reply_byte <= gen_byte;
      reply_last <= (idx == last_idx);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hci_h4_command_responder.sv =====
`timescale 1ns / 1ps
`default_nettype none

// H4 command responder: host bytes enter on push/full, one per cycle while
// full is low; bytes before an H4 command type byte are dropped. Each
// complete command is answered with a Command Complete event delivered on
// empty/pop, one byte per cycle while pop is held, reply_last marking its
// final byte. The parser and the event generator are parted by a two-entry
// command queue, so full rises only when two finished commands wait behind
// the reply in progress; each reply takes a setup step, then its 7 to 15
// bytes pass through the single output register of the generator.
// Configuration writes are taken every cycle (cfg_ready is always high).
module hci_h4_command_responder (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic [7:0]                      host_byte,
  output logic                                 empty,
  input  wire logic                            pop,
  output logic [7:0]                           reply_byte,
  output logic                                 reply_last,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [hcir_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [hcir_pkg::CFG_DATA_W-1:0] cfg_data
);
  import hcir_pkg::*;

  cmd_t cmd_in;
  cmd_t cmd_out;
  logic cmd_push;
  logic cmd_full;
  logic cmd_pop;
  logic cmd_empty;
  logic out_valid;
  logic in_xfer;

  assign full      = cmd_full;
  assign in_xfer   = push && !cmd_full;
  assign empty     = !out_valid;
  assign cfg_ready = 1'b1;

  hcir_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_xfer   (in_xfer),
    .host_byte (host_byte),
    .cmd       (cmd_in),
    .cmd_push  (cmd_push)
  );

  hcir_cmdq u_cmdq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_push),
    .wr_data (cmd_in),
    .q_full  (cmd_full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_out),
    .q_empty (cmd_empty)
  );

  hcir_responder u_responder (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd_out),
    .cmd_empty  (cmd_empty),
    .cmd_pop    (cmd_pop),
    .cfg_wr     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_take   (pop && out_valid),
    .reply_byte (reply_byte),
    .reply_last (reply_last)
  );

endmodule

`default_nettype wire
